// ===== rtl/lagged_xor_random_range_core_defines.svh =====
// Assertion macros for the checker of the lagged XOR generator.
`ifndef LAGGED_XOR_RANDOM_RANGE_CORE_DEFINES_SVH
`define LAGGED_XOR_RANDOM_RANGE_CORE_DEFINES_SVH

// Assert a property on the rising clock edge, off while reset is low.
`define LXR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assert that a condition never holds on a rising clock edge outside reset.
`define LXR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== rtl/lxr_pkg.sv =====
// ----------------------------------------------------------------------------
// lxr_pkg
// Shared widths, constants and the controller command type of the lagged XOR
// byte generator.
// ----------------------------------------------------------------------------
package lxr_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = BYTE_W + VAL_W;

  // Divide by the full-scale byte through its reciprocal:
  // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for every x below 2^PROD_W.
  // The quotient never exceeds VAL_W bits, so the product is kept to
  // RECIP_SHIFT + VAL_W bits.
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;
  localparam int QPROD_W     = RECIP_SHIFT + VAL_W;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'h0101_0102;

  localparam logic [BYTE_W:0] FULL_SCALE = 9'd255;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic rd_a;      // read short-lag entry
    logic rd_b;      // read long-lag entry, capture short-lag data
    logic mul;       // form new byte, write it back, scale by width
    logic div_step;  // divide the scaled product by the full-scale byte
    logic load_out;  // load the output register
  } lxr_cmd_t;

endpackage

// ===== rtl/lagged_xor_random_range_core.sv =====
// ----------------------------------------------------------------------------
// lagged_xor_random_range_core
// Lagged XOR byte generator over a 64-entry ring with mapping into a range.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer.
//   operation_i = 0 stores seed_value_i at seed_index_i and clears the
//   position; operation_i = 1 draws a byte from the ring and maps it into
//   [range_low_i, range_high_i). One result per command leaves on the output
//   channel (out_valid_o/out_ready_i).
//   A seed write goes straight to the output load; a draw passes through two
//   ring reads, one scale step, one divide step by reciprocal multiply and
//   one output load. One command is in work at a time, and the next transfer
//   is taken only once the sequencer is back in its idle state.
//   The output register holds a finished result while the receiver stalls;
//   a new command is taken meanwhile, and its result waits in the
//   sequencer until the register is free.
//   Reset empties the ring (all entries read as zero until written) and
//   clears the position and the output valid flag at once.
// ----------------------------------------------------------------------------
module lagged_xor_random_range_core
  import lxr_pkg::*;
#(
  parameter int SHORT_LAG = 24,
  parameter int LONG_LAG  = 55
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [RING_AW-1:0] seed_index_i,
  input  logic [BYTE_W-1:0]  seed_value_i,
  input  logic [VAL_W-1:0]   range_low_i,
  input  logic [VAL_W-1:0]   range_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  raw_byte_o,
  output logic [VAL_W-1:0]   ranged_value_o,
  output logic               range_error_o
);

  lxr_cmd_t cmd;

  // Sequencer
  lxr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Ring, scaler and output payload
  lxr_datapath #(
    .SHORT_LAG (SHORT_LAG),
    .LONG_LAG  (LONG_LAG)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .seed_index_i   (seed_index_i),
    .seed_value_i   (seed_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .raw_byte_o     (raw_byte_o),
    .ranged_value_o (ranged_value_o),
    .range_error_o  (range_error_o)
  );

endmodule

// ===== rtl/lxr_ram.sv =====
// ----------------------------------------------------------------------------
// lxr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lxr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lxr_ctrl
// Sequencer of the generator: handshakes, ring reads, the divide step and the
// output register's valid flag.
// ----------------------------------------------------------------------------
module lxr_ctrl
  import lxr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     operation_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lxr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic                 out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = (operation_i == OP_DRAW) ? S_RDA : S_FIN;
        end
      end
      S_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Set valid on load, drop it on an output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/lxr_datapath.sv =====
// ----------------------------------------------------------------------------
// lxr_datapath
// History ring, position counter, byte scaler with divide-by-255 unit and the
// output payload register.
// ----------------------------------------------------------------------------
module lxr_datapath
  import lxr_pkg::*;
#(
  parameter int SHORT_LAG = 24,
  parameter int LONG_LAG  = 55
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lxr_cmd_t           cmd_i,
  input  logic               operation_i,
  input  logic [RING_AW-1:0] seed_index_i,
  input  logic [BYTE_W-1:0]  seed_value_i,
  input  logic [VAL_W-1:0]   range_low_i,
  input  logic [VAL_W-1:0]   range_high_i,
  output logic [BYTE_W-1:0]  raw_byte_o,
  output logic [VAL_W-1:0]   ranged_value_o,
  output logic               range_error_o
);

  localparam logic [RING_AW-1:0] SHORT_OFS = RING_AW'(SHORT_LAG % RING_DEPTH);
  localparam logic [RING_AW-1:0] LONG_OFS  = RING_AW'(LONG_LAG % RING_DEPTH);

  logic [RING_AW-1:0]    pos_q, pos_d;
  logic [RING_DEPTH-1:0] vld_q, vld_d;
  logic                  rvld_q;
  logic                  op_q;
  logic [VAL_W-1:0]      lo_q, hi_q;
  logic [BYTE_W-1:0]     a_q, byte_q;
  logic                  err_q;
  logic [PROD_W-1:0]     div_q;
  logic [VAL_W-1:0]      quot_q;
  logic [BYTE_W-1:0]     raw_q;
  logic [VAL_W-1:0]      ranged_q;
  logic                  rerr_q;

  logic                  ram_we;
  logic [RING_AW-1:0]    ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;
  logic [BYTE_W-1:0]     b_val, new_byte;
  logic [VAL_W-1:0]      width;
  logic [VAL_W-1:0]      scaled;
  logic [QPROD_W-1:0]    qprod;

  // Ring storage
  lxr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Select read slot behind the current position
  assign ram_raddr = cmd_i.rd_b ? (pos_q - LONG_OFS) : (pos_q - SHORT_OFS);

  // Write seed on accept, new byte on the scale step
  assign b_val     = rvld_q ? ram_rdata : '0;
  assign new_byte  = a_q ^ b_val;
  assign ram_we    = (cmd_i.accept && (operation_i == OP_SEED)) || cmd_i.mul;
  assign ram_waddr = cmd_i.mul ? pos_q : seed_index_i;
  assign ram_wdata = cmd_i.mul ? new_byte : seed_value_i;

  // Track written entries; unwritten ones read as zero
  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  // Advance or clear the position
  always_comb begin
    pos_d = pos_q;
    if (cmd_i.accept) begin
      pos_d = (operation_i == OP_DRAW) ? pos_q + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      vld_q  <= vld_d;
      rvld_q <= vld_q[ram_raddr];
    end
  end

  assign width = hi_q - lo_q;

  // Divide-by-255 unit: multiply by the reciprocal, keep the quotient bits
  assign qprod = QPROD_W'(div_q) * QPROD_W'(RECIP_255);

  // A full-scale byte maps to width itself, which wraps to zero
  assign scaled = (byte_q == FULL_SCALE[BYTE_W-1:0]) ? '0 : quot_q;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= operation_i;
      lo_q <= range_low_i;
      hi_q <= range_high_i;
    end
    if (cmd_i.rd_b) begin
      a_q <= b_val;
    end
    if (cmd_i.mul) begin
      byte_q <= new_byte;
      err_q  <= (hi_q <= lo_q);
      div_q  <= PROD_W'(new_byte) * PROD_W'(width);
    end
    if (cmd_i.div_step) begin
      quot_q <= qprod[RECIP_SHIFT +: VAL_W];
    end
    if (cmd_i.load_out) begin
      if (op_q == OP_DRAW) begin
        raw_q    <= byte_q;
        ranged_q <= err_q ? lo_q : lo_q + scaled;
        rerr_q   <= err_q;
      end else begin
        raw_q    <= '0;
        ranged_q <= lo_q;
        rerr_q   <= 1'b0;
      end
    end
  end

  assign raw_byte_o     = raw_q;
  assign ranged_value_o = ranged_q;
  assign range_error_o  = rerr_q;

endmodule

// ===== rtl/lxr_checker.sv =====
// ----------------------------------------------------------------------------
// lxr_checker
// Port-level checks of the lagged XOR generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lagged_xor_random_range_core_defines.svh"

module lxr_checker
  import lxr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               operation_i,
  input logic [RING_AW-1:0] seed_index_i,
  input logic [BYTE_W-1:0]  seed_value_i,
  input logic [VAL_W-1:0]   range_low_i,
  input logic [VAL_W-1:0]   range_high_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [BYTE_W-1:0]  raw_byte_o,
  input logic [VAL_W-1:0]   ranged_value_o,
  input logic               range_error_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  // One command in work: ready drops right after an input transfer
  `LXR_ASSERT(a_one_in_work, clk_i, rst_ni, in_xfer |=> !in_ready_o, "ready held after input transfer")

  // No result appears the cycle after an input transfer
  `LXR_ASSERT(a_no_early_result, clk_i, rst_ni, in_xfer |=> !$rose(out_valid_o), "result too early")

  // Hold a stalled result
  `LXR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(raw_byte_o) && $stable(ranged_value_o) && $stable(range_error_o), "stalled result changed")

  // A new result carries a known error flag
  `LXR_NEVER(a_err_valid, clk_i, rst_ni, $rose(out_valid_o) && $isunknown(range_error_o), "unknown error flag")

endmodule

bind lagged_xor_random_range_core lxr_checker u_lxr_checker (.*);

// ===== tb/sv/lagged_xor_random_range_core_tb.sv =====
// ----------------------------------------------------------------------------
// lagged_xor_random_range_core_tb
// Self-checking bench for the lagged XOR byte generator. A table of directed
// commands (empty ring, inverted and empty ranges, seed extremes, full-scale
// byte) is followed by random seed-fill and draw sessions with noise mixed in.
// Results are checked against typed table entries or an in-bench copy of the
// ring, position and range mapping; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lagged_xor_random_range_core_tb;
  import lxr_pkg::*;

  localparam int SHORT_LAG      = 24;
  localparam int LONG_LAG       = 55;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_ERR_PRINTS = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic [VAL_W-1:0]  ranged;
    logic              err;
  } gen_result_t;

  typedef struct {
    logic               op;
    logic [RING_AW-1:0] idx;
    logic [BYTE_W-1:0]  val;
    logic [VAL_W-1:0]   lo;
    logic [VAL_W-1:0]   hi;
    bit                 typed;
    gen_result_t        exp;
  } gen_cmd_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               operation_i    = OP_SEED;
  logic [RING_AW-1:0] seed_index_i   = '0;
  logic [BYTE_W-1:0]  seed_value_i   = '0;
  logic [VAL_W-1:0]   range_low_i    = '0;
  logic [VAL_W-1:0]   range_high_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [BYTE_W-1:0]  raw_byte_o;
  logic [VAL_W-1:0]   ranged_value_o;
  logic               range_error_o;

  // Typed expectation that travels with the command on the input channel
  bit                 typed_chk      = 1'b0;
  gen_result_t        typed_result   = '0;

  // Bench copy of the generator state
  logic [BYTE_W-1:0]  ring_copy [RING_DEPTH];
  logic [RING_AW-1:0] position_copy = '0;

  gen_result_t        pending_outputs[$];
  gen_cmd_t           directed_rows[$];

  int  error_count     = 0;
  int  items_sent      = 0;
  int  burst_left      = 1;
  int  seeds_taken     = 0;
  int  draws_taken     = 0;
  int  range_errors    = 0;
  int  long_holds      = 0;
  bit  hold_off_request = 1'b0;

  lagged_xor_random_range_core #(
    .SHORT_LAG (SHORT_LAG),
    .LONG_LAG  (LONG_LAG)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .seed_index_i   (seed_index_i),
    .seed_value_i   (seed_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .raw_byte_o     (raw_byte_o),
    .ranged_value_o (ranged_value_o),
    .range_error_o  (range_error_o)
  );

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Reset: clear the bench ring copy, hold reset low, then release
  initial begin
    for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the bench copy of the generator by one command
  function automatic gen_result_t step_generator(logic op, logic [RING_AW-1:0] idx,
                                                 logic [BYTE_W-1:0] val,
                                                 logic [VAL_W-1:0] lo,
                                                 logic [VAL_W-1:0] hi);
    gen_result_t        r;
    logic [RING_AW-1:0] slot_short;
    logic [RING_AW-1:0] slot_long;
    logic [BYTE_W-1:0]  new_byte;
    int unsigned        width;
    int unsigned        scaled;
    int unsigned        sum;
    r.raw    = '0;
    r.ranged = lo;
    r.err    = 1'b0;
    if (op == OP_SEED) begin
      ring_copy[idx] = val;
      position_copy  = '0;
    end else begin
      position_copy = position_copy + 1'b1;
      slot_short    = position_copy - RING_AW'(SHORT_LAG);
      slot_long     = position_copy - RING_AW'(LONG_LAG);
      new_byte      = ring_copy[slot_short] ^ ring_copy[slot_long];
      ring_copy[position_copy] = new_byte;
      r.raw = new_byte;
      if (hi > lo) begin
        width    = int'(hi) - int'(lo);
        scaled   = (int'(new_byte) * width) / int'(FULL_SCALE);
        sum      = int'(lo) + (scaled % width);
        r.ranged = VAL_W'(sum);
      end else begin
        r.err = 1'b1;
      end
    end
    return r;
  endfunction

  // Predict on each input transfer, check on each output transfer
  always @(posedge clk_i) begin
    gen_result_t predicted;
    gen_result_t exp;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = step_generator(operation_i, seed_index_i, seed_value_i,
                                   range_low_i, range_high_i);
        if (operation_i == OP_SEED) seeds_taken++;
        else                        draws_taken++;
        pending_outputs.push_back(typed_chk ? typed_result : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (range_error_o) range_errors++;
        if (pending_outputs.size() == 0) begin
          error_count++;
          if (error_count <= MAX_ERR_PRINTS)
            $error("unexpected result: raw_byte %0h ranged_value %0h range_error %0b",
                   raw_byte_o, ranged_value_o, range_error_o);
        end else begin
          exp = pending_outputs.pop_front();
          if (raw_byte_o !== exp.raw) begin
            error_count++;
            if (error_count <= MAX_ERR_PRINTS)
              $error("raw_byte: expected %0h, got %0h", exp.raw, raw_byte_o);
          end
          if (ranged_value_o !== exp.ranged) begin
            error_count++;
            if (error_count <= MAX_ERR_PRINTS)
              $error("ranged_value: expected %0h, got %0h", exp.ranged, ranged_value_o);
          end
          if (range_error_o !== exp.err) begin
            error_count++;
            if (error_count <= MAX_ERR_PRINTS)
              $error("range_error: expected %0b, got %0b", exp.err, range_error_o);
          end
        end
      end
    end
  end

  // Receiver: stall on changing patterns, hold off for a long stretch on request
  initial begin : receiver
    int mode;
    int span;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        if (hold_off_request) begin
          out_ready_i <= 1'b0;
          repeat (RX_HOLD_CYCLES) @(posedge clk_i);
          hold_off_request = 1'b0;
          long_holds++;
        end
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready_i <= ((k % 4) == 0);
          end
          default: begin
            out_ready_i <= ($urandom_range(0, 15) != 0);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offer one command and hold it until its transfer; idle between bursts
  task automatic send_item(input gen_cmd_t c);
    operation_i  <= c.op;
    seed_index_i <= c.idx;
    seed_value_i <= c.val;
    range_low_i  <= c.lo;
    range_high_i <= c.hi;
    typed_chk    <= c.typed;
    typed_result <= c.exp;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_row(logic op, logic [RING_AW-1:0] idx, logic [BYTE_W-1:0] val,
                                  logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi, bit typed,
                                  logic [BYTE_W-1:0] raw, logic [VAL_W-1:0] ranged,
                                  logic err);
    gen_cmd_t c;
    c.op         = op;
    c.idx        = idx;
    c.val        = val;
    c.lo         = lo;
    c.hi         = hi;
    c.typed      = typed;
    c.exp.raw    = raw;
    c.exp.ranged = ranged;
    c.exp.err    = err;
    directed_rows.push_back(c);
  endfunction

  // Random command; the range is biased toward its corner cases
  function automatic gen_cmd_t random_cmd(logic op);
    gen_cmd_t c;
    c.op    = op;
    c.idx   = RING_AW'($urandom_range(0, RING_DEPTH - 1));
    c.val   = BYTE_W'($urandom_range(0, 255));
    c.typed = 1'b0;
    c.exp   = '0;
    c.lo    = VAL_W'($urandom_range(0, 16'hFFFF));
    c.hi    = VAL_W'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 9))
      0: begin
        c.hi = c.lo;
      end
      1: begin
        if (c.lo < c.hi) begin
          c.lo = c.hi;
          c.hi = VAL_W'($urandom_range(0, c.lo));
        end
      end
      2: begin
        c.lo = '0;
        c.hi = 16'hFFFF;
      end
      3: begin
        if (c.lo > 16'hFFEF) c.lo = 16'hFFEF;
        c.hi = c.lo + VAL_W'($urandom_range(1, 16));
      end
      4: begin
        if (c.lo > 16'hFEFF) c.lo = 16'hFEFF;
        c.hi = c.lo + VAL_W'($urandom_range(255, 256));
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // Stimulus
  initial begin : stimulus
    int  fill_count;
    int  draw_count;
    bit  full_fill;
    bit  drain_done;
    bit  hold_done;
    gen_cmd_t c;

    drain_done = 1'b0;
    hold_done  = 1'b0;

    // Draws on the empty ring, range corners, seed extremes, full-scale byte
    add_row(OP_DRAW, 6'd0,  8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'd100,  16'd100,  1'b1, 8'h00, 16'd100,  1'b1);
    add_row(OP_DRAW, 6'd63, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 16'hFFFF, 1'b1);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'hFFFE, 16'hFFFF, 1'b1, 8'h00, 16'hFFFE, 1'b0);
    add_row(OP_SEED, 6'd0,  8'hFF, 16'h1234, 16'h0000, 1'b1, 8'h00, 16'h1234, 1'b0);
    add_row(OP_SEED, 6'd63, 8'h80, 16'hFFFF, 16'hFFFF, 1'b1, 8'h00, 16'hFFFF, 1'b0);
    add_row(OP_SEED, 6'd41, 8'hFF, 16'h0000, 16'hFFFF, 1'b1, 8'h00, 16'h0000, 1'b0);
    add_row(OP_SEED, 6'd10, 8'h00, 16'h0007, 16'h0003, 1'b1, 8'h00, 16'h0007, 1'b0);
    add_row(OP_SEED, 6'd42, 8'hA5, 16'h8000, 16'h0001, 1'b1, 8'h00, 16'h8000, 1'b0);
    add_row(OP_SEED, 6'd11, 8'h0F, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'h0000, 16'hFFFF, 1'b0, '0, '0, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'h0000, 16'h00FF, 1'b0, '0, '0, 1'b0);
    add_row(OP_SEED, 6'd41, 8'hFF, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'd1000, 16'd1001, 1'b0, '0, '0, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'd7,    16'd3,    1'b0, '0, '0, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'hFF00, 16'hFFFF, 1'b0, '0, '0, 1'b0);
    add_row(OP_SEED, 6'd21, 8'h3C, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0000, 1'b0);
    add_row(OP_DRAW, 6'd0,  8'h00, 16'h0005, 16'h0006, 1'b0, '0, '0, 1'b0);

    wait (rst_ni);
    @(posedge clk_i);
    burst_left = $urandom_range(1, 60);

    // Walk the directed table
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_outputs();

    // Random sessions: seed fills followed by draw runs, with some noise
    while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
      if (!drain_done && items_sent > RANDOM_ITEMS / 4) begin
        drain_outputs();
        drain_done = 1'b1;
      end
      if (!hold_done && items_sent > RANDOM_ITEMS / 2) begin
        hold_off_request = 1'b1;
        hold_done        = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        full_fill  = ($urandom_range(0, 2) == 0);
        fill_count = full_fill ? RING_DEPTH : $urandom_range(1, 24);
        for (int k = 0; k < fill_count; k++) begin
          c = random_cmd(OP_SEED);
          if (full_fill) c.idx = RING_AW'(k);
          send_item(c);
        end
        draw_count = $urandom_range(1, 140);
        for (int k = 0; k < draw_count; k++) begin
          // Break a run now and then with a stray seed write
          if ($urandom_range(0, 63) == 0) send_item(random_cmd(OP_SEED));
          else                            send_item(random_cmd(OP_DRAW));
        end
      end else begin
        repeat ($urandom_range(1, 10)) send_item(random_cmd(1'($urandom_range(0, 1))));
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d seed writes and %0d draws, %0d of them on an empty or inverted range",
             seeds_taken, draws_taken, range_errors);
    $display("Receiver held off %0d time(s) for %0d cycles; %0d field mismatches",
             long_holds, RX_HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
